### rtl/core/afc_pkg.sv
`default_nettype none

package afc_pkg;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 31;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ADJ_LIM   = 3'd5;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] RST_STIFFNESS = 31'd3932;
  localparam logic [CFG_DATA_W-1:0] RST_DAMPING   = 31'd7864;
  localparam logic [CFG_DATA_W-1:0] RST_INV_MASS  = 31'd21845333;
  localparam logic [CFG_DATA_W-1:0] RST_TIME_STEP = 31'd524;
  localparam logic [CFG_DATA_W-1:0] RST_SPEED_LIM = 31'd5242880;
  localparam logic [CFG_DATA_W-1:0] RST_ADJ_LIM   = 31'd1310720;

  typedef struct packed {
    logic [CFG_DATA_W-1:0] stiffness_gain;
    logic [CFG_DATA_W-1:0] damping_gain;
    logic [CFG_DATA_W-1:0] inv_mass;
    logic [CFG_DATA_W-1:0] time_step;
    logic [CFG_DATA_W-1:0] speed_limit;
    logic [CFG_DATA_W-1:0] adjust_limit;
  } cfg_regs_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_KP,
    ST_NUM,
    ST_MUL_IM,
    ST_ACC,
    ST_MUL_DT1,
    ST_SPEED,
    ST_MUL_DT2,
    ST_ADJ
  } state_t;

  // operand pairs for the shared multiplier
  typedef enum logic [2:0] {
    MUL_SPEED_KD,
    MUL_ADJ_KP,
    MUL_NUM_IM,
    MUL_ACC_DT,
    MUL_SPEED_DT
  } mul_sel_t;

  typedef struct packed {
    logic     accept;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ld_kd_term;
    logic     ld_num;
    logic     ld_acc;
    logic     ld_speed;
    logic     ld_adj;
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_status_t;

endpackage

`default_nettype wire

### rtl/core/admittance_force_controller_unit.sv
`default_nettype none

// One axis of an admittance force controller. Each input transaction carries a
// measured and a target force (signed fixed point, FRAC_BITS fraction bits) and
// a restart flag; each produces exactly one output transaction with the clamped
// position adjustment and the speed and adjustment clamp flags. The five products
// of a step run one after another through a single shared 32x31 multiplier,
// each product registered and then rescaled and saturated in its own cycle,
// before the result is loaded into the output register. Items are handled one
// at a time; the next one is accepted the cycle after the result is loaded,
// while that result still waits in the output register. If the previous
// result has not yet been taken, the final step waits for it.
// The user must write gains and limits through the cfg port only while the
// block is idle; the block itself does not enforce this. Indexes above 5
// are ignored.
module admittance_force_controller_unit #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // input stream
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [63:0]                     s_tdata,   // measured_force, target_force
  input  wire logic                            s_tuser,   // restart
  // output stream
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic [31:0]                          m_tdata,   // adjustment
  output logic [1:0]                           m_tuser    // speed_clamped, adjust_clamped
);

  afc_pkg::cfg_regs_t  regs;
  afc_pkg::dp_cmd_t    cmd;
  afc_pkg::dp_status_t status;

  afc_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  afc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  afc_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .regs       (regs),
    .cmd        (cmd),
    .status     (status),
    .in_data    (s_tdata),
    .in_restart (s_tuser),
    .out_data   (m_tdata),
    .out_user   (m_tuser),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready)
  );

endmodule

`default_nettype wire

### rtl/core/afc_regs.sv
`default_nettype none

module afc_regs (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_we,
  input  wire logic [afc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [afc_pkg::CFG_DATA_W-1:0]  cfg_data,
  output afc_pkg::cfg_regs_t                   regs
);

  // register file, writes beyond the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.stiffness_gain <= afc_pkg::RST_STIFFNESS;
      regs.damping_gain   <= afc_pkg::RST_DAMPING;
      regs.inv_mass       <= afc_pkg::RST_INV_MASS;
      regs.time_step      <= afc_pkg::RST_TIME_STEP;
      regs.speed_limit    <= afc_pkg::RST_SPEED_LIM;
      regs.adjust_limit   <= afc_pkg::RST_ADJ_LIM;
    end else if (cfg_we) begin
      unique case (cfg_index)
        afc_pkg::REG_STIFFNESS: regs.stiffness_gain <= cfg_data;
        afc_pkg::REG_DAMPING:   regs.damping_gain   <= cfg_data;
        afc_pkg::REG_INV_MASS:  regs.inv_mass       <= cfg_data;
        afc_pkg::REG_TIME_STEP: regs.time_step      <= cfg_data;
        afc_pkg::REG_SPEED_LIM: regs.speed_limit    <= cfg_data;
        afc_pkg::REG_ADJ_LIM:   regs.adjust_limit   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/core/afc_ctrl.sv
`default_nettype none

module afc_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire afc_pkg::dp_status_t  status,
  output afc_pkg::dp_cmd_t          cmd
);

  afc_pkg::state_t state;
  afc_pkg::state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= afc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      afc_pkg::ST_IDLE:    if (s_tvalid) state_next = afc_pkg::ST_MUL_KP;
      afc_pkg::ST_MUL_KP:  state_next = afc_pkg::ST_NUM;
      afc_pkg::ST_NUM:     state_next = afc_pkg::ST_MUL_IM;
      afc_pkg::ST_MUL_IM:  state_next = afc_pkg::ST_ACC;
      afc_pkg::ST_ACC:     state_next = afc_pkg::ST_MUL_DT1;
      afc_pkg::ST_MUL_DT1: state_next = afc_pkg::ST_SPEED;
      afc_pkg::ST_SPEED:   state_next = afc_pkg::ST_MUL_DT2;
      afc_pkg::ST_MUL_DT2: state_next = afc_pkg::ST_ADJ;
      afc_pkg::ST_ADJ:     if (!status.out_busy) state_next = afc_pkg::ST_IDLE;
      default:             state_next = afc_pkg::ST_IDLE;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = afc_pkg::MUL_SPEED_KD;
    s_tready = 1'b0;
    unique case (state)
      afc_pkg::ST_IDLE: begin
        s_tready    = 1'b1;
        cmd.accept  = s_tvalid;
        cmd.mul_en  = s_tvalid;
        cmd.mul_sel = afc_pkg::MUL_SPEED_KD;
      end
      afc_pkg::ST_MUL_KP: begin
        cmd.ld_kd_term = 1'b1;
        cmd.mul_en     = 1'b1;
        cmd.mul_sel    = afc_pkg::MUL_ADJ_KP;
      end
      afc_pkg::ST_NUM: begin
        cmd.ld_num = 1'b1;
      end
      afc_pkg::ST_MUL_IM: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = afc_pkg::MUL_NUM_IM;
      end
      afc_pkg::ST_ACC: begin
        cmd.ld_acc = 1'b1;
      end
      afc_pkg::ST_MUL_DT1: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = afc_pkg::MUL_ACC_DT;
      end
      afc_pkg::ST_SPEED: begin
        cmd.ld_speed = 1'b1;
      end
      afc_pkg::ST_MUL_DT2: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = afc_pkg::MUL_SPEED_DT;
      end
      afc_pkg::ST_ADJ: begin
        cmd.ld_adj = !status.out_busy;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/afc_dpath.sv
`default_nettype none

module afc_dpath #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire afc_pkg::cfg_regs_t  regs,
  input  wire afc_pkg::dp_cmd_t    cmd,
  output afc_pkg::dp_status_t      status,
  input  wire logic [63:0]         in_data,   // measured_force, target_force
  input  wire logic                in_restart,
  output logic [31:0]              out_data,  // adjustment
  output logic [1:0]               out_user,  // speed_clamped, adjust_clamped
  output logic                     out_valid,
  input  wire logic                out_ready
);

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  logic signed [31:0] meas;
  logic signed [31:0] targ;
  logic signed [31:0] err;
  logic signed [31:0] kd_term;
  logic signed [31:0] num;
  logic signed [31:0] acc;
  logic signed [31:0] speed;
  logic signed [31:0] adjust;
  logic               speed_hit;
  logic signed [63:0] prod;

  logic signed [31:0] mul_a;
  logic [30:0]        mul_g;
  logic signed [63:0] prod_shr;
  logic signed [31:0] prod_fx;
  logic signed [31:0] err_next;
  logic signed [33:0] num_sum;
  logic signed [31:0] num_next;
  logic signed [32:0] speed_sum;
  logic signed [32:0] adj_sum;
  logic [32:0]        speed_clamp;
  logic [32:0]        adj_clamp;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) begin
      r = S32_MAX[31:0];
    end else if (v < S32_MIN) begin
      r = S32_MIN[31:0];
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // returns {hit, value}
  function automatic logic [32:0] clamp_sym(input logic signed [31:0] v,
                                            input logic [30:0] lim);
    logic signed [32:0] l;
    logic signed [32:0] l_neg;
    logic signed [32:0] vx;
    logic [32:0]        r;
    l     = $signed({2'b00, lim});
    l_neg = -l;
    vx    = {v[31], v};
    if (vx > l) begin
      r = {1'b1, l[31:0]};
    end else if (vx < l_neg) begin
      r = {1'b1, l_neg[31:0]};
    end else begin
      r = {1'b0, v};
    end
    return r;
  endfunction

  assign status.out_busy = out_valid && !out_ready;

  // shared multiplier operand select
  always_comb begin
    mul_a = speed;
    mul_g = regs.damping_gain;
    case (cmd.mul_sel)
      afc_pkg::MUL_SPEED_KD: begin
        mul_a = in_restart ? 32'sd0 : speed;
        mul_g = regs.damping_gain;
      end
      afc_pkg::MUL_ADJ_KP: begin
        mul_a = adjust;
        mul_g = regs.stiffness_gain;
      end
      afc_pkg::MUL_NUM_IM: begin
        mul_a = num;
        mul_g = regs.inv_mass;
      end
      afc_pkg::MUL_ACC_DT: begin
        mul_a = acc;
        mul_g = regs.time_step;
      end
      afc_pkg::MUL_SPEED_DT: begin
        mul_a = speed;
        mul_g = regs.time_step;
      end
      default: ;
    endcase
  end

  // rescale of the registered product, floor then saturate
  always_comb begin
    prod_shr = prod >>> FRAC_BITS;
    prod_fx  = sat32(prod_shr);
  end

  // sums with saturation and clamping
  always_comb begin
    err_next    = sat32(64'(meas) - 64'(targ));
    num_sum     = 34'(err) - 34'(kd_term) - 34'(prod_fx);
    num_next    = sat32(64'(num_sum));
    speed_sum   = 33'(speed) + 33'(prod_fx);
    adj_sum     = 33'(adjust) + 33'(prod_fx);
    speed_clamp = clamp_sym(sat32(64'(speed_sum)), regs.speed_limit);
    adj_clamp   = clamp_sym(sat32(64'(adj_sum)), regs.adjust_limit);
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * $signed({1'b0, mul_g});
    end
    if (cmd.accept) begin
      meas <= in_data[31:0];
      targ <= in_data[63:32];
    end
    if (cmd.ld_kd_term) begin
      kd_term <= prod_fx;
      err     <= err_next;
    end
    if (cmd.ld_num) begin
      num <= num_next;
    end
    if (cmd.ld_acc) begin
      acc <= prod_fx;
    end
    if (cmd.ld_speed) begin
      speed_hit <= speed_clamp[32];
    end
  end

  // integrator state
  always_ff @(posedge clk) begin
    if (rst) begin
      speed  <= '0;
      adjust <= '0;
    end else begin
      if (cmd.accept && in_restart) begin
        speed  <= '0;
        adjust <= '0;
      end
      if (cmd.ld_speed) begin
        speed <= speed_clamp[31:0];
      end
      if (cmd.ld_adj) begin
        adjust <= adj_clamp[31:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.ld_adj) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_adj) begin
      out_data <= adj_clamp[31:0];
      out_user <= {adj_clamp[32], speed_hit};
    end
  end

endmodule

`default_nettype wire

### rtl/core/afc_checker.sv
`default_nettype none

module afc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [1:0]  m_tuser
);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
    else $error("output payload changed while stalled");

  // one item at a time: no acceptance right after an acceptance
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while a step is in progress");

  // no result right out of reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind admittance_force_controller_unit afc_checker u_afc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/admittance_force_controller_unit_tb.sv
`default_nettype none

module admittance_force_controller_unit_tb;

  localparam int unsigned FRAC = 16;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned RANDOM_PHASES = 9;
  localparam int unsigned ITEMS_PER_PHASE = 150;
  localparam int unsigned MAX_REPORTS = 100;

  // register indexes that hold no register
  localparam logic [afc_pkg::CFG_IDX_W-1:0] REG_NONE_LO = 3'd6;
  localparam logic [afc_pkg::CFG_IDX_W-1:0] REG_NONE_HI = 3'd7;

  localparam logic [afc_pkg::CFG_DATA_W-1:0] REG_MAX = 31'h7FFFFFFF;
  localparam logic signed [31:0] FORCE_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] FORCE_MIN = 32'sh80000000;
  localparam longint S32_MAX = 64'sd2147483647;
  localparam longint S32_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [31:0] adjustment;
    logic               speed_clamped;
    logic               adjust_clamped;
  } axis_result_t;

  // tracks one axis of the controller and holds the adjustments still owed
  class axis_admittance_tracker;
    logic [afc_pkg::CFG_DATA_W-1:0] kp, kd, inv_m, dt, speed_lim, adjust_lim;
    logic signed [31:0]             speed, adjust;
    axis_result_t                   owed_results_q[$];
    int unsigned                    failures;

    function new();
      kp = afc_pkg::RST_STIFFNESS;
      kd = afc_pkg::RST_DAMPING;
      inv_m = afc_pkg::RST_INV_MASS;
      dt = afc_pkg::RST_TIME_STEP;
      speed_lim = afc_pkg::RST_SPEED_LIM;
      adjust_lim = afc_pkg::RST_ADJ_LIM;
      speed = '0;
      adjust = '0;
      failures = 0;
    endfunction

    function logic signed [31:0] sat32(longint v);
      if (v > S32_MAX) return S32_MAX[31:0];
      if (v < S32_MIN) return S32_MIN[31:0];
      return v[31:0];
    endfunction

    // signed value times unsigned gain, floor rescale, saturate
    function logic signed [31:0] scale(logic signed [31:0] a,
                                       logic [afc_pkg::CFG_DATA_W-1:0] g);
      longint prod;
      prod = longint'(a) * longint'(g);
      return sat32(prod >>> FRAC);
    endfunction

    function logic signed [31:0] clamp_sym(logic signed [31:0] v,
                                           logic [afc_pkg::CFG_DATA_W-1:0] lim,
                                           output logic hit);
      longint l;
      longint l_neg;
      l = longint'(lim);
      l_neg = -l;
      hit = 1'b0;
      if (longint'(v) > l) begin
        hit = 1'b1;
        return l[31:0];
      end
      if (longint'(v) < l_neg) begin
        hit = 1'b1;
        return l_neg[31:0];
      end
      return v;
    endfunction

    function void set_reg(logic [afc_pkg::CFG_IDX_W-1:0] idx,
                          logic [afc_pkg::CFG_DATA_W-1:0] val);
      case (idx)
        afc_pkg::REG_STIFFNESS: kp = val;
        afc_pkg::REG_DAMPING:   kd = val;
        afc_pkg::REG_INV_MASS:  inv_m = val;
        afc_pkg::REG_TIME_STEP: dt = val;
        afc_pkg::REG_SPEED_LIM: speed_lim = val;
        afc_pkg::REG_ADJ_LIM:   adjust_lim = val;
        default: ;
      endcase
    endfunction

    // one control step per accepted force sample
    function void note_force_sample(logic signed [31:0] meas, logic signed [31:0] targ,
                                    logic restart);
      logic signed [31:0] err, num, acc;
      axis_result_t       res;
      if (restart) begin
        speed = '0;
        adjust = '0;
      end
      err = sat32(longint'(meas) - longint'(targ));
      num = sat32(longint'(err) - longint'(scale(speed, kd)) - longint'(scale(adjust, kp)));
      acc = scale(num, inv_m);
      speed = sat32(longint'(speed) + longint'(scale(acc, dt)));
      speed = clamp_sym(speed, speed_lim, res.speed_clamped);
      adjust = sat32(longint'(adjust) + longint'(scale(speed, dt)));
      adjust = clamp_sym(adjust, adjust_lim, res.adjust_clamped);
      res.adjustment = adjust;
      owed_results_q.insert(owed_results_q.size(), res);
    endfunction

    function void report(string what, longint exp_val, longint act_val);
      failures++;
      // keep the log short when the block is badly off
      if (failures <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, exp_val, act_val);
    endfunction

    function void check_adjust_result(logic [31:0] data, logic [1:0] flags);
      axis_result_t exp_res;
      if (owed_results_q.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("%0t: unexpected output transaction, adjustment %0d flags %b",
                   $time, $signed(data), flags);
        return;
      end
      exp_res = owed_results_q.pop_front();
      if (data !== exp_res.adjustment)
        report("adjustment", exp_res.adjustment, $signed(data));
      if (flags[0] !== exp_res.speed_clamped)
        report("speed_clamped", exp_res.speed_clamped, flags[0]);
      if (flags[1] !== exp_res.adjust_clamped)
        report("adjust_clamped", exp_res.adjust_clamped, flags[1]);
    endfunction

    function int unsigned owed();
      return owed_results_q.size();
    endfunction
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [afc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [afc_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [63:0]                    s_tdata = '0;   // measured_force, target_force
  logic                           s_tuser = 1'b0; // restart
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [31:0]                    m_tdata;        // adjustment
  logic [1:0]                     m_tuser;        // speed_clamped, adjust_clamped

  axis_admittance_tracker tracker;
  int unsigned cycle_count = 0;
  int unsigned ready_mode = 0;
  int unsigned ready_left = 0;

  admittance_force_controller_unit #(
    .FRAC_BITS(FRAC)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // cycle counter and watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // monitors for both streams
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      tracker.note_force_sample($signed(s_tdata[31:0]), $signed(s_tdata[63:32]), s_tuser);
    if (!rst && m_tvalid && m_tready)
      tracker.check_adjust_result(m_tdata, m_tuser);
  end

  // receiver back-pressure: runs of always ready, mostly ready and mostly stalled
  always @(negedge clk) begin
    if (ready_left == 0) begin
      ready_mode <= $urandom_range(0, 2);
      ready_left <= $urandom_range(1, 60);
    end else begin
      ready_left <= ready_left - 1;
    end
    case (ready_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic send_item(logic signed [31:0] meas, logic signed [31:0] targ, logic restart);
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tdata = {targ, meas};
    s_tuser = restart;
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic pause(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
  endtask

  // hold off the sender until every owed result is out, then let the block settle
  task automatic wait_idle();
    pause(1);
    while (tracker.owed() != 0) @(posedge clk);
    pause(SETTLE_CYCLES);
  endtask

  task automatic write_reg(logic [afc_pkg::CFG_IDX_W-1:0] idx,
                           logic [afc_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    tracker.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [afc_pkg::CFG_DATA_W-1:0] pick_reg(
      logic [afc_pkg::CFG_DATA_W-1:0] typical);
    case ($urandom_range(0, 7))
      0: return '0;
      1: return REG_MAX;
      2: return 31'($urandom);
      3: return 31'($urandom_range(0, 1 << 18));
      default: return typical / 2 + 31'($urandom_range(0, typical));
    endcase
  endfunction

  function automatic logic signed [31:0] pick_force();
    case ($urandom_range(0, 9))
      0: return FORCE_MAX;
      1: return FORCE_MIN;
      2, 3, 4: return $urandom;
      default: return $signed($urandom_range(0, 80 << FRAC)) - (40 << FRAC);
    endcase
  endfunction

  initial begin
    int unsigned burst_left;
    logic signed [31:0] lim_val;

    tracker = new();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // reset gains: saturated errors both ways, then a steady push
    send_item(FORCE_MAX, FORCE_MIN, 1'b1);
    send_item(FORCE_MIN, FORCE_MAX, 1'b0);
    send_item(0, 0, 1'b1);
    repeat (4) send_item(10 << FRAC, 0, 1'b0);

    // zero inverse mass keeps speed constant
    wait_idle();
    write_reg(afc_pkg::REG_INV_MASS, '0);
    send_item(FORCE_MAX, FORCE_MIN, 1'b0);
    send_item(1234, -99, 1'b0);

    // zero time step freezes both states
    wait_idle();
    write_reg(afc_pkg::REG_INV_MASS, afc_pkg::RST_INV_MASS);
    write_reg(afc_pkg::REG_TIME_STEP, '0);
    send_item(FORCE_MAX, 0, 1'b0);
    send_item(-5 << FRAC, 7 << FRAC, 1'b0);

    // zero limits force both values to zero
    wait_idle();
    write_reg(afc_pkg::REG_TIME_STEP, afc_pkg::RST_TIME_STEP);
    write_reg(afc_pkg::REG_SPEED_LIM, '0);
    write_reg(afc_pkg::REG_ADJ_LIM, '0);
    send_item(FORCE_MAX, FORCE_MIN, 1'b1);
    send_item(FORCE_MIN, 3, 1'b0);

    // unit mass and step so a value lands exactly on its limit
    wait_idle();
    lim_val = 3 << FRAC;
    write_reg(afc_pkg::REG_STIFFNESS, '0);
    write_reg(afc_pkg::REG_DAMPING, '0);
    write_reg(afc_pkg::REG_INV_MASS, 31'(1 << FRAC));
    write_reg(afc_pkg::REG_TIME_STEP, 31'(1 << FRAC));
    write_reg(afc_pkg::REG_SPEED_LIM, lim_val[30:0]);
    write_reg(afc_pkg::REG_ADJ_LIM, lim_val[30:0]);
    send_item(lim_val, 0, 1'b1);
    send_item(lim_val + 1, 0, 1'b1);
    send_item(-lim_val, 0, 1'b1);
    send_item(0, lim_val + 1, 1'b1);

    // all registers at their maximum, writes to missing indexes must not land
    wait_idle();
    write_reg(afc_pkg::REG_STIFFNESS, REG_MAX);
    write_reg(afc_pkg::REG_DAMPING, REG_MAX);
    write_reg(afc_pkg::REG_INV_MASS, REG_MAX);
    write_reg(afc_pkg::REG_TIME_STEP, REG_MAX);
    write_reg(afc_pkg::REG_SPEED_LIM, REG_MAX);
    write_reg(afc_pkg::REG_ADJ_LIM, REG_MAX);
    write_reg(REG_NONE_LO, '0);
    write_reg(REG_NONE_HI, '0);
    send_item(FORCE_MAX, FORCE_MIN, 1'b1);
    send_item(FORCE_MIN, FORCE_MAX, 1'b0);
    send_item(0, 0, 1'b0);

    // random phases, each with its own register setting and bursty traffic
    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      write_reg(afc_pkg::REG_STIFFNESS, pick_reg(afc_pkg::RST_STIFFNESS));
      write_reg(afc_pkg::REG_DAMPING, pick_reg(afc_pkg::RST_DAMPING));
      write_reg(afc_pkg::REG_INV_MASS, pick_reg(afc_pkg::RST_INV_MASS));
      write_reg(afc_pkg::REG_TIME_STEP, pick_reg(afc_pkg::RST_TIME_STEP));
      write_reg(afc_pkg::REG_SPEED_LIM, pick_reg(afc_pkg::RST_SPEED_LIM));
      write_reg(afc_pkg::REG_ADJ_LIM, pick_reg(afc_pkg::RST_ADJ_LIM));
      burst_left = $urandom_range(1, 30);
      for (int unsigned n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_item(pick_force(), pick_force(),
                  (n == 0) ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 19) == 0));
        if (burst_left == 0) begin
          pause($urandom_range(1, 12));
          burst_left = $urandom_range(1, 30);
        end else begin
          burst_left--;
        end
      end
    end

    wait_idle();
    if (tracker.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

### files.f
rtl/core/afc_pkg.sv
rtl/core/afc_regs.sv
rtl/core/afc_ctrl.sv
rtl/core/afc_dpath.sv
rtl/core/admittance_force_controller_unit.sv
rtl/core/afc_checker.sv
tb/admittance_force_controller_unit_tb.sv
